/* rtl/rpnsc_pkg.sv */
// Package for the RPN stack calculator: action codes, status codes, widths.
// No dependencies.
package rpnsc_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned ActW        = 4;
  localparam int unsigned StatW       = 2;
  localparam int unsigned DefDepth    = 16;
  localparam int unsigned MaxResults  = 16;

  typedef enum logic [ActW-1:0] {
    ACT_PUSH  = 4'd0,
    ACT_PTOP  = 4'd1,
    ACT_PALL  = 4'd2,
    ACT_PPOP  = 4'd3,
    ACT_CLEAR = 4'd4,
    ACT_DUP   = 4'd5,
    ACT_SWAP  = 4'd6,
    ACT_ADD   = 4'd7,
    ACT_SUB   = 4'd8,
    ACT_MUL   = 4'd9,
    ACT_DIV   = 4'd10,
    ACT_REM   = 4'd11
  } act_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } stat_e;

endpackage

/* rtl/rpn_stack_calculator_unit.sv */
// RPN stack calculator top level: stack memory, sequencer, serial divider.
// Depends on rpnsc_pkg.
//
// Channel | Dir | tdata (low bit up)                          | tuser  | tlast
// s_axis  | in  | action[3:0], push_value[35:4], zero[39:36]  | -      | -
// m_axis  | out | result_value[31:0], status[33:32], 0[39:34] | has_value | last
//
// Every request passes through accept, the reads RD1 and RD2 and execute before
// its result is offered; swap adds a second write state (WR2) before output.
// Div/rem add the 32 steps of the one-bit-a-cycle restoring divider and DIVEND.
// Print all then takes read, data and output states for each entry it prints.
// Reset clears the stack count only; the store needs no clearing. A held result
// stalls in the output register; the next request waits for the last result.
module rpn_stack_calculator_unit #(
  parameter int unsigned STACK_DEPTH = rpnsc_pkg::DefDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // action, push_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // result_value, status
  output logic        m_axis_tuser,   // has_value
  output logic        m_axis_tlast
);
  import rpnsc_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FullC = CW'(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_DIVEND, S_WR2, S_DUMP, S_DUMPW, S_OUT
  } state_e;

  // stack memory, one write and one registered read port
  logic [DataW-1:0] mem [STACK_DEPTH];
  logic             we;
  logic [AW-1:0]    wa, ra;
  logic [DataW-1:0] wd, rd_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  state_e           state_q;
  logic [CW-1:0]    cnt_q;
  act_e             act_q;
  logic [DataW-1:0] pv_q, a_q, b_q;
  logic [CW-1:0]    dn_q;
  logic [4:0]       dk_q;       // dump results remaining - 1
  logic [5:0]       it_q;
  logic [DataW-1:0] quo_q, rem_q, dvs_q;
  logic             neg_q, qneg_q;
  logic [DataW-1:0] ov_q;
  logic             oh_q, ol_q;
  stat_e            os_q;

  logic [CW-1:0] top;
  assign top = cnt_q - CW'(1);

  // combinational memory controls
  always_comb begin
    we = 1'b0;
    wa = top[AW-1:0];
    wd = a_q;
    ra = top[AW-1:0];
    case (state_q)
      S_IDLE:  ra = top[AW-1:0];
      S_RD1:   ra = AW'(cnt_q - CW'(2));
      S_DUMP:  ra = dn_q[AW-1:0];
      default: ;
    endcase
    if (state_q == S_EXEC) begin
      case (act_q)
        ACT_PUSH: begin
          we = (cnt_q != FullC); wa = cnt_q[AW-1:0]; wd = pv_q;
        end
        ACT_DUP: begin
          we = (cnt_q != 0) && (cnt_q != FullC); wa = cnt_q[AW-1:0]; wd = b_q;
        end
        ACT_SWAP: begin
          we = (cnt_q >= CW'(2)); wa = top[AW-1:0]; wd = a_q;
        end
        ACT_ADD: begin
          we = (cnt_q >= CW'(2)); wa = AW'(cnt_q - CW'(2)); wd = a_q + b_q;
        end
        ACT_SUB: begin
          we = (cnt_q >= CW'(2)); wa = AW'(cnt_q - CW'(2)); wd = a_q - b_q;
        end
        ACT_MUL: begin
          we = (cnt_q >= CW'(2)); wa = AW'(cnt_q - CW'(2));
          wd = DataW'(a_q * b_q);
        end
        default: ;
      endcase
    end else if (state_q == S_WR2) begin
      we = 1'b1; wa = AW'(cnt_q - CW'(2)); wd = b_q;
    end else if (state_q == S_DIVEND) begin
      we = 1'b1; wa = AW'(cnt_q - CW'(2));
      wd = (act_q == ACT_DIV) ? (qneg_q ? -quo_q : quo_q) : (neg_q ? -rem_q : rem_q);
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {6'd0, os_q, ov_q};
  assign m_axis_tuser  = oh_q;
  assign m_axis_tlast  = ol_q;

  // divider step: shift in next dividend bit
  logic [DataW:0]   trial;
  logic [DataW-1:0] rsh;
  assign rsh   = {rem_q[DataW-2:0], quo_q[DataW-1]};
  assign trial = {1'b0, rsh} - {1'b0, dvs_q};

  // sequencer with registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (s_axis_tvalid) begin
          act_q <= act_e'(s_axis_tdata[3:0]);
          pv_q  <= s_axis_tdata[35:4];
          state_q <= S_RD1;
        end
        // top read issued in idle; second issued here
        S_RD1: begin
          b_q <= rd_q;
          state_q <= S_RD2;
        end
        S_RD2: begin
          a_q <= rd_q;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          ov_q <= '0; oh_q <= 1'b0; ol_q <= 1'b1; os_q <= ST_OK;
          state_q <= S_OUT;
          case (act_q)
            ACT_PUSH: if (cnt_q == FullC) os_q <= ST_OVER;
                      else cnt_q <= cnt_q + CW'(1);
            ACT_PTOP, ACT_PPOP: begin
              if (cnt_q == 0) os_q <= ST_UNDER;
              else begin
                ov_q <= b_q; oh_q <= 1'b1;
                if (act_q == ACT_PPOP) cnt_q <= top;
              end
            end
            ACT_PALL: if (cnt_q != 0) begin
              dn_q <= top;
              dk_q <= (32'(cnt_q) > MaxResults) ? 5'(MaxResults - 1) : 5'(top);
              state_q <= S_DUMP;
            end
            ACT_CLEAR: cnt_q <= '0;
            ACT_DUP: if (cnt_q == 0) os_q <= ST_UNDER;
                     else if (cnt_q == FullC) os_q <= ST_OVER;
                     else cnt_q <= cnt_q + CW'(1);
            ACT_SWAP: if (cnt_q < CW'(2)) os_q <= ST_UNDER;
                      else state_q <= S_WR2;
            ACT_ADD, ACT_SUB, ACT_MUL:
              if (cnt_q < CW'(2)) os_q <= ST_UNDER;
              else cnt_q <= top;
            ACT_DIV, ACT_REM: begin
              if (cnt_q < CW'(2)) os_q <= ST_UNDER;
              else if (b_q == 0) begin
                os_q <= ST_DIVZ; cnt_q <= cnt_q - CW'(2);
              end else begin
                neg_q  <= a_q[DataW-1];
                qneg_q <= a_q[DataW-1] ^ b_q[DataW-1];
                quo_q  <= a_q[DataW-1] ? -a_q : a_q;
                dvs_q  <= b_q[DataW-1] ? -b_q : b_q;
                rem_q  <= '0;
                it_q   <= '0;
                state_q <= S_DIV;
              end
            end
            default: ;
          endcase
        end
        // one quotient bit per cycle
        S_DIV: begin
          if (!trial[DataW]) begin
            rem_q <= trial[DataW-1:0];
            quo_q <= {quo_q[DataW-2:0], 1'b1};
          end else begin
            rem_q <= rsh;
            quo_q <= {quo_q[DataW-2:0], 1'b0};
          end
          it_q <= it_q + 6'd1;
          if (it_q == 6'(DataW - 1)) state_q <= S_DIVEND;
        end
        S_DIVEND: begin
          cnt_q <= top;
          state_q <= S_OUT;
        end
        S_WR2: state_q <= S_OUT;
        // dump: read issued here, data next cycle
        S_DUMP: state_q <= S_DUMPW;
        S_DUMPW: begin
          ov_q <= rd_q; oh_q <= 1'b1; os_q <= ST_OK;
          ol_q <= (dk_q == 0);
          state_q <= S_OUT;
        end
        S_OUT: if (m_axis_tready) begin
          if (!ol_q) begin
            dn_q <= dn_q - CW'(1);
            dk_q <= dk_q - 5'd1;
            state_q <= S_DUMP;
          end else state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* verif/tb_top.sv */
// Testbench for rpn_stack_calculator_unit: directed and random action streams,
// checked against an in-bench stack predictor. Depends on rpnsc_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
  import rpnsc_pkg::*;

  localparam int unsigned Depth    = DefDepth;
  localparam int unsigned WdogMax  = 20000;
  localparam int unsigned DrainCyc = 200;

  typedef struct packed {
    logic [31:0] value;
    logic        has;
    stat_e       status;
    logic        last;
  } calc_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // action, push_value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // result_value, status
  logic        m_axis_tuser;        // has_value
  logic        m_axis_tlast;

  // predictor state
  logic [31:0] model_stack [Depth];
  int unsigned model_count = 0;
  calc_res_t   expected_q[$];

  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned requests_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off = 1'b0;
  int unsigned idle_cycles = 0;
  bit          done = 1'b0;

  always #2 clk_i = ~clk_i;

  rpn_stack_calculator_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  function automatic void push_exp(logic [31:0] v, logic h, stat_e s, logic l);
    calc_res_t r;
    r.value = v; r.has = h; r.status = s; r.last = l;
    expected_q.push_back(r);
  endfunction

  // arithmetic for binary actions on a = second, b = top
  function automatic logic [31:0] arith(act_e op, logic [31:0] a, logic [31:0] b);
    logic signed [32:0] sa, sb;
    logic signed [32:0] q;
    sa = $signed({a[31], a});
    sb = $signed({b[31], b});
    case (op)
      ACT_ADD: arith = a + b;
      ACT_SUB: arith = a - b;
      ACT_MUL: arith = a * b;
      ACT_DIV: begin
        q = sa / sb;
        arith = q[31:0];
      end
      default: begin
        q = sa % sb;
        arith = q[31:0];
      end
    endcase
  endfunction

  // work out the results one action causes and update the stack copy
  function automatic void predict_action(logic [3:0] act, logic [31:0] pv);
    stat_e       st;
    logic [31:0] t;
    int unsigned n;
    st = ST_OK;
    case (act)
      ACT_PUSH: begin
        if (model_count >= Depth) st = ST_OVER;
        else begin
          model_stack[model_count] = pv;
          model_count++;
        end
      end
      ACT_PTOP, ACT_PPOP: begin
        if (model_count == 0) st = ST_UNDER;
        else begin
          t = model_stack[model_count-1];
          if (act == ACT_PPOP) model_count--;
          push_exp(t, 1'b1, ST_OK, 1'b1);
          return;
        end
      end
      ACT_PALL: begin
        n = (model_count < MaxResults) ? model_count : MaxResults;
        if (n != 0) begin
          for (int unsigned k = 0; k < n; k++)
            push_exp(model_stack[model_count-1-k], 1'b1, ST_OK, k + 1 == n);
          return;
        end
      end
      ACT_CLEAR: model_count = 0;
      ACT_DUP: begin
        if (model_count == 0) st = ST_UNDER;
        else if (model_count >= Depth) st = ST_OVER;
        else begin
          model_stack[model_count] = model_stack[model_count-1];
          model_count++;
        end
      end
      ACT_SWAP: begin
        if (model_count < 2) st = ST_UNDER;
        else begin
          t = model_stack[model_count-1];
          model_stack[model_count-1] = model_stack[model_count-2];
          model_stack[model_count-2] = t;
        end
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_REM: begin
        if (model_count < 2) st = ST_UNDER;
        else begin
          model_count -= 2;
          if ((act == ACT_DIV || act == ACT_REM) && model_stack[model_count+1] == 0)
            st = ST_DIVZ;
          else begin
            model_stack[model_count] = arith(act_e'(act), model_stack[model_count],
                                             model_stack[model_count+1]);
            model_count++;
          end
        end
      end
      default: ;
    endcase
    push_exp('0, 1'b0, st, 1'b1);
  endfunction

  // send one request; predict at acceptance
  task automatic send_request(logic [3:0] act, logic [31:0] pv);
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
      @(negedge clk_i);
    s_axis_tdata  <= {4'b0, pv, act};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_action(act, pv);
    requests_sent++;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // receiver ready, with random stalls and an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    calc_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $time,
                 m_axis_tdata[31:0], m_axis_tdata[33:32]);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata[31:0] !== e.value || m_axis_tuser !== e.has ||
            m_axis_tdata[33:32] !== e.status || m_axis_tlast !== e.last ||
            m_axis_tdata[39:34] !== 6'b0) begin
          $display({"%0t: mismatch exp val=%h has=%b st=%0d last=%b",
                    " got val=%h has=%b st=%0d last=%b"},
                   $time, e.value, e.has, e.status, e.last, m_axis_tdata[31:0],
                   m_axis_tuser, m_axis_tdata[33:32], m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with nothing accepted
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
      idle_cycles <= 0;
    else if (!done) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WdogMax) begin
        $display("%0t: watchdog expired", $time);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5, 0))
      0: rand_value = 32'h8000_0000;
      1: rand_value = 32'h7FFF_FFFF;
      2: rand_value = 32'hFFFF_FFFF;
      3: rand_value = $urandom_range(7, 0);
      default: rand_value = $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_request(ACT_PTOP, 0);              // underflow on empty
    send_request(ACT_PPOP, 0);
    send_request(ACT_PALL, 0);              // empty dump
    send_request(ACT_DUP, 0);
    send_request(ACT_SWAP, 0);
    send_request(ACT_PUSH, 32'h8000_0000);
    send_request(ACT_ADD, 0);               // partial underflow keeps stack
    send_request(ACT_PUSH, 32'hFFFF_FFFF);
    send_request(ACT_DIV, 32'hFFFF_FFFF);   // most negative / -1
    send_request(ACT_PUSH, 32'h8000_0000);
    send_request(ACT_PUSH, 32'hFFFF_FFFF);
    send_request(ACT_REM, 0);
    send_request(ACT_PUSH, 32'h7FFF_FFFF);
    send_request(ACT_SWAP, 0);
    send_request(ACT_PUSH, 0);
    send_request(ACT_DIV, 0);               // divide by zero drops both
    send_request(ACT_PUSH, -7);
    send_request(ACT_PUSH, 2);
    send_request(ACT_REM, 0);
    send_request(ACT_PUSH, 5);
    send_request(ACT_MUL, 0);
    send_request(ACT_SUB, 0);
    send_request(ACT_PPOP, 0);
    send_request(4'd12, 32'hA5A5_A5A5);     // unknown action
    send_request(4'd15, 0);
  endtask

  // fill to the top, overflow, dump all sixteen
  task automatic test_full_stack();
    send_request(ACT_CLEAR, 0);
    for (int i = 0; i < Depth; i++) send_request(ACT_PUSH, rand_value());
    send_request(ACT_PUSH, 1);
    send_request(ACT_DUP, 0);
    send_request(ACT_PALL, 0);
    send_request(ACT_CLEAR, 0);
  endtask

  // random mix biased towards a well-filled stack
  task automatic test_random(int unsigned n);
    logic [3:0] act;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(19, 0))
        0, 1, 2, 3, 4: act = (model_count < 3 || $urandom_range(1, 0)) ? ACT_PUSH
                             : 4'($urandom_range(11, 1));
        5: act = ACT_PALL;
        6: act = (model_count > 12) ? ACT_CLEAR : ACT_DUP;
        7: act = 4'($urandom_range(15, 12));
        default: act = 4'($urandom_range(11, 0));
      endcase
      send_request(act, rand_value());
    end
  endtask

  // stall the receiver for a long time while requests keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      test_random(20);
    join
  endtask

  initial begin
    for (int i = 0; i < Depth; i++) model_stack[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_full_stack();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(100);
    send_idle_pct = 49; recv_stall_pct = 0;  test_random(100);
    send_idle_pct = 0;  recv_stall_pct = 49; test_random(100);
    send_idle_pct = 23; recv_stall_pct = 23; test_random(100);
    send_idle_pct = 0;  recv_stall_pct = 0;  test_backpressure();

    wait_drained();
    repeat (DrainCyc) @(posedge clk_i);
    done = 1'b1;
    $display("Covered %0d requests and %0d results: all actions, under/overflow,",
             requests_sent, results_seen);
    $display("divide by zero, full-stack dumps and long output stalls.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
